/* hdl/wlaf_pkg.sv */
// Shared types, constants and character helpers for the word length alpha filter.
package wlaf_pkg;

    // Longest word the buffer holds; longer words are dropped.
    localparam int MAX_WORD  = 16;
    localparam int IDX_W     = $clog2(MAX_WORD);
    localparam int LEN_W     = $clog2(MAX_WORD + 1);
    // Two banks: one for the word being built, one for the longest kept word.
    localparam int MEM_DEPTH = 2 ** (IDX_W + 1);
    localparam int MIN_W     = 5;
    localparam int COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [MIN_W-1:0]   MIN_LENGTH_RESET = MIN_W'(3);

    typedef enum logic [1:0] {
        KIND_WORD    = 2'd0,
        KIND_LONG    = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FINISH,
        ST_LINE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic take_item;
        logic finish_word;
        logic start_word_emit;
        logic start_long_emit;
        logic load_byte;
        logic commit_word;
        logic load_summary;
    } cmd_t;

    typedef struct packed {
        logic item_finish;
        logic line_end;
        logic word_empty;
        logic word_keep;
        logic longest_empty;
        logic idx_last;
        logic src_long;
        logic out_free;
    } status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
    endfunction

endpackage

/* hdl/wlaf_ctrl.sv */
// Sequencer for the word length alpha filter: walks each transaction through its phases.
module wlaf_ctrl
    import wlaf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!status.item_finish) begin
                    state_next = ST_IDLE;
                end else if (status.word_empty) begin
                    state_next = ST_LINE;
                end else begin
                    cmd.finish_word = 1'b1;
                    if (status.word_keep) begin
                        cmd.start_word_emit = 1'b1;
                        state_next          = ST_EMIT_RD;
                    end else begin
                        state_next = ST_LINE;
                    end
                end
            end
            ST_LINE: begin
                if (!status.line_end) begin
                    state_next = ST_IDLE;
                end else if (status.longest_empty) begin
                    state_next = ST_SUMMARY;
                end else begin
                    cmd.start_long_emit = 1'b1;
                    state_next          = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (status.out_free) begin
                    cmd.load_byte = 1'b1;
                    if (!status.idx_last) begin
                        state_next = ST_EMIT_RD;
                    end else if (status.src_long) begin
                        state_next = ST_SUMMARY;
                    end else begin
                        cmd.commit_word = 1'b1;
                        state_next      = ST_LINE;
                    end
                end
            end
            ST_SUMMARY: begin
                if (status.out_free) begin
                    cmd.load_summary = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/wlaf_datapath.sv */
// Datapath of the word length alpha filter: word buffers, counters and result register.
module wlaf_datapath
    import wlaf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               cfg_wr_en,
    input  logic [MIN_W-1:0]   cfg_wr_data,
    input  logic               s_has_byte,
    input  logic [7:0]         s_text_in,
    input  logic               s_line_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_result_kind,
    output logic [7:0]         m_text_out,
    output logic               m_run_last,
    output logic [COUNT_W-1:0] m_words_seen,
    output logic [COUNT_W-1:0] m_words_kept,
    output logic               m_overlong_seen
);

    logic [7:0] mem [MEM_DEPTH];

    logic [MIN_W-1:0]   min_length_reg;
    logic               line_end_reg;
    logic               space_reg;
    logic               word_bank_reg;
    logic [LEN_W-1:0]   word_len_reg;
    logic               all_letters_reg;
    logic               ovf_reg;
    logic [LEN_W-1:0]   longest_len_reg;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] kept_reg;
    logic               overlong_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               src_long_reg;
    logic [7:0]         rd_data_reg;

    logic               out_valid_reg;
    logic [1:0]         out_kind_reg;
    logic [7:0]         out_text_reg;
    logic               out_last_reg;
    logic [COUNT_W-1:0] out_seen_reg;
    logic [COUNT_W-1:0] out_kept_reg;
    logic               out_ovf_reg;

    logic               in_space;
    logic               wr_en;
    logic [IDX_W:0]     wr_addr;
    logic [IDX_W:0]     rd_addr;
    logic [LEN_W-1:0]   src_len;
    logic               out_free;
    logic               word_keep;

    assign in_space  = is_space(s_text_in);
    assign wr_en     = cmd.take_item && s_has_byte && !in_space
                       && (word_len_reg < LEN_W'(MAX_WORD));
    assign wr_addr   = {word_bank_reg, word_len_reg[IDX_W-1:0]};
    assign rd_addr   = {src_long_reg ? ~word_bank_reg : word_bank_reg, idx_reg};
    assign src_len   = src_long_reg ? longest_len_reg : word_len_reg;
    assign out_free  = !out_valid_reg || m_ready;
    assign word_keep = !ovf_reg && all_letters_reg
                       && (MIN_W'(word_len_reg) >= min_length_reg);

    assign status.item_finish   = space_reg || line_end_reg;
    assign status.line_end      = line_end_reg;
    assign status.word_empty    = (word_len_reg == '0) && !ovf_reg;
    assign status.word_keep     = word_keep;
    assign status.longest_empty = (longest_len_reg == '0);
    assign status.idx_last      = (LEN_W'(idx_reg) + LEN_W'(1)) == src_len;
    assign status.src_long      = src_long_reg;
    assign status.out_free      = out_free;

    // Word buffer memory: one write port at transaction intake, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= to_lower(s_text_in);
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg  <= MIN_LENGTH_RESET;
            line_end_reg    <= 1'b0;
            space_reg       <= 1'b0;
            word_bank_reg   <= 1'b0;
            word_len_reg    <= '0;
            all_letters_reg <= 1'b1;
            ovf_reg         <= 1'b0;
            longest_len_reg <= '0;
            seen_reg        <= '0;
            kept_reg        <= '0;
            overlong_reg    <= 1'b0;
            idx_reg         <= '0;
            src_long_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                min_length_reg <= cfg_wr_data;
            end
            if (cmd.take_item) begin
                line_end_reg <= s_line_end;
                space_reg    <= s_has_byte && in_space;
                if (s_has_byte && !in_space) begin
                    if (!is_letter(s_text_in)) begin
                        all_letters_reg <= 1'b0;
                    end
                    if (word_len_reg < LEN_W'(MAX_WORD)) begin
                        word_len_reg <= word_len_reg + LEN_W'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
            if (cmd.finish_word) begin
                if (seen_reg != COUNT_MAX) begin
                    seen_reg <= seen_reg + COUNT_W'(1);
                end
                if (ovf_reg) begin
                    overlong_reg <= 1'b1;
                end
                if (word_keep) begin
                    if (kept_reg != COUNT_MAX) begin
                        kept_reg <= kept_reg + COUNT_W'(1);
                    end
                end else begin
                    word_len_reg    <= '0;
                    all_letters_reg <= 1'b1;
                    ovf_reg         <= 1'b0;
                end
            end
            if (cmd.start_word_emit || cmd.start_long_emit) begin
                idx_reg      <= '0;
                src_long_reg <= cmd.start_long_emit;
            end
            if (cmd.load_byte) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.commit_word) begin
                // A strictly longer word takes over: swap bank roles instead of copying.
                if (word_len_reg > longest_len_reg) begin
                    longest_len_reg <= word_len_reg;
                    word_bank_reg   <= ~word_bank_reg;
                end
                word_len_reg    <= '0;
                all_letters_reg <= 1'b1;
                ovf_reg         <= 1'b0;
            end
            if (cmd.load_summary) begin
                longest_len_reg <= '0;
                seen_reg        <= '0;
                kept_reg        <= '0;
                overlong_reg    <= 1'b0;
                word_len_reg    <= '0;
                all_letters_reg <= 1'b1;
                ovf_reg         <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_byte || cmd.load_summary) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            out_kind_reg <= src_long_reg ? KIND_LONG : KIND_WORD;
            out_text_reg <= rd_data_reg;
            out_last_reg <= !src_long_reg && status.idx_last && !line_end_reg;
            out_seen_reg <= '0;
            out_kept_reg <= '0;
            out_ovf_reg  <= 1'b0;
        end else if (cmd.load_summary) begin
            out_kind_reg <= KIND_SUMMARY;
            out_text_reg <= '0;
            out_last_reg <= 1'b1;
            out_seen_reg <= seen_reg;
            out_kept_reg <= kept_reg;
            out_ovf_reg  <= overlong_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_text_out      = out_text_reg;
    assign m_run_last      = out_last_reg;
    assign m_words_seen    = out_seen_reg;
    assign m_words_kept    = out_kept_reg;
    assign m_overlong_seen = out_ovf_reg;

`ifndef ASSERT_OFF
    a_summary_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == KIND_SUMMARY) |-> out_last_reg)
        else $error("summary result without run_last");

    a_kept_le_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_reg <= seen_reg)
        else $error("kept count exceeds seen count");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_len_reg <= LEN_W'(MAX_WORD)) && (longest_len_reg <= LEN_W'(MAX_WORD)))
        else $error("word length beyond buffer size");

    a_line_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_summary |=> (seen_reg == '0 && kept_reg == '0
                              && longest_len_reg == '0 && !overlong_reg))
        else $error("line state not cleared after summary");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(cmd.load_byte || cmd.load_summary))
        else $error("result register loaded while stalled");
`endif

endmodule

/* hdl/word_length_alpha_filter.sv */
// Top level of the word length alpha filter: sequencer plus datapath.
//
// Usage: each input transaction on s_* carries at most one byte of a text line
// (s_has_byte qualifies s_text_in) and may end the line with s_line_end.
// Words are split at whitespace, lower-cased and buffered; a finished word of
// letters only and of min_length to 16 characters comes out byte by byte on
// m_* as kind 0. At line end the first longest kept word follows as kind 1
// bytes, then one summary (kind 2) with the seen and kept word counts and the
// overlong flag. m_run_last marks the last result of an input transaction.
// Each emitted byte is first read from the buffer memory and then loaded
// into the output register. The output register lets the next transaction
// be taken while a result still waits. If m_ready stays low, emission holds
// with no loss. min_length is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Reset (aresetn low, synchronous) holds s_ready low,
// clears counts, lengths and flags, drops any pending result and sets
// min_length to 3; the buffer memory is not cleared.
module word_length_alpha_filter
    import wlaf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [MIN_W-1:0]   cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_has_byte,
    input  logic [7:0]         s_text_in,
    input  logic               s_line_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_result_kind,
    output logic [7:0]         m_text_out,
    output logic               m_run_last,
    output logic [COUNT_W-1:0] m_words_seen,
    output logic [COUNT_W-1:0] m_words_kept,
    output logic               m_overlong_seen
);

    // Command and status bundles between the sequencer and the datapath.
    cmd_t    cmd;
    status_t status;

    // The sequencer owns s_ready; it is high only between transactions.
    wlaf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the word buffers, the counters and the output register.
    wlaf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_has_byte      (s_has_byte),
        .s_text_in       (s_text_in),
        .s_line_end      (s_line_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_text_out      (m_text_out),
        .m_run_last      (m_run_last),
        .m_words_seen    (m_words_seen),
        .m_words_kept    (m_words_kept),
        .m_overlong_seen (m_overlong_seen)
    );

endmodule

/* tb/wlaf_scoreboard_pkg.sv */
// Scoreboard class for the word length alpha filter: line predictor and output checker.
`timescale 1ns / 1ps

package wlaf_scoreboard_pkg;
    import wlaf_pkg::*;

    class word_filter_scoreboard;
        typedef struct {
            kind_t              kind;
            logic [7:0]         text;
            logic               last;
            logic [COUNT_W-1:0] seen;
            logic [COUNT_W-1:0] kept;
            logic               overlong;
        } filter_output_t;

        // Outputs still owed by the block, oldest first.
        filter_output_t     due_outputs[$];
        logic [MIN_W-1:0]   min_len;
        logic [7:0]         word_buf[MAX_WORD];
        int                 word_len;
        bit                 letters_only;
        bit                 word_too_long;
        logic [7:0]         longest_buf[MAX_WORD];
        int                 longest_len;
        logic [COUNT_W-1:0] seen_words;
        logic [COUNT_W-1:0] kept_words;
        bit                 line_overlong;
        int                 mismatches;
        int                 outputs_checked;

        function new();
            min_len         = MIN_LENGTH_RESET;
            word_len        = 0;
            letters_only    = 1'b1;
            word_too_long   = 1'b0;
            longest_len     = 0;
            seen_words      = '0;
            kept_words      = '0;
            line_overlong   = 1'b0;
            mismatches      = 0;
            outputs_checked = 0;
        endfunction

        function void set_min_length(input logic [MIN_W-1:0] value);
            min_len = value;
        endfunction

        function int pending();
            return due_outputs.size();
        endfunction

        function void add_output(input kind_t kind, input logic [7:0] text,
                                 input logic [COUNT_W-1:0] seen,
                                 input logic [COUNT_W-1:0] kept, input logic overlong);
            filter_output_t item;
            item.kind     = kind;
            item.text     = text;
            item.last     = 1'b0;
            item.seen     = seen;
            item.kept     = kept;
            item.overlong = overlong;
            due_outputs.insert(due_outputs.size(), item);
        endfunction

        // A word boundary: count the word, and emit it if it passes both filters.
        function void end_word();
            int idx;
            if (word_len == 0 && !word_too_long) begin
                return;
            end
            if (seen_words != COUNT_MAX) begin
                seen_words++;
            end
            if (word_too_long) begin
                line_overlong = 1'b1;
            end else if (word_len >= min_len && letters_only) begin
                for (idx = 0; idx < word_len; idx++) begin
                    add_output(KIND_WORD, word_buf[idx], '0, '0, 1'b0);
                end
                if (kept_words != COUNT_MAX) begin
                    kept_words++;
                end
                // Only a strictly longer word takes over the longest slot.
                if (word_len > longest_len) begin
                    longest_buf = word_buf;
                    longest_len = word_len;
                end
            end
            word_len      = 0;
            letters_only  = 1'b1;
            word_too_long = 1'b0;
        endfunction

        function void note_input(input bit has_byte, input logic [7:0] c, input bit line_end);
            int first;
            int idx;
            first = due_outputs.size();
            if (has_byte) begin
                if (c inside {8'h20, [8'h09:8'h0D]}) begin
                    end_word();
                end else begin
                    if (!(c inside {[8'h41:8'h5A], [8'h61:8'h7A]})) begin
                        letters_only = 1'b0;
                    end
                    if (word_len < MAX_WORD) begin
                        word_buf[word_len] = (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
                        word_len++;
                    end else begin
                        word_too_long = 1'b1;
                    end
                end
            end
            if (line_end) begin
                end_word();
                for (idx = 0; idx < longest_len; idx++) begin
                    add_output(KIND_LONG, longest_buf[idx], '0, '0, 1'b0);
                end
                add_output(KIND_SUMMARY, 8'h00, seen_words, kept_words, line_overlong);
                longest_len   = 0;
                seen_words    = '0;
                kept_words    = '0;
                line_overlong = 1'b0;
            end
            if (due_outputs.size() > first) begin
                due_outputs[due_outputs.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_output(input logic [1:0] kind, input logic [7:0] text,
                                   input logic last, input logic [COUNT_W-1:0] seen,
                                   input logic [COUNT_W-1:0] kept, input logic overlong);
            filter_output_t want;
            outputs_checked++;
            if (due_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("output %0d arrived with nothing owed: kind %0d text %02h",
                             outputs_checked, kind, text);
                end
                return;
            end
            want = due_outputs.pop_front();
            if (kind !== want.kind || text !== want.text || last !== want.last ||
                seen !== want.seen || kept !== want.kept || overlong !== want.overlong) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("output %0d wrong: got kind %0d text %02h last %0b seen %0d kept %0d overlong %0b",
                             outputs_checked, kind, text, last, seen, kept, overlong);
                    $display("    wanted kind %0d text %02h last %0b seen %0d kept %0d overlong %0b",
                             want.kind, want.text, want.last, want.seen, want.kept,
                             want.overlong);
                end
            end
        endfunction
    endclass

endpackage

/* tb/word_length_alpha_filter_tb.sv */
// Testbench top for the word length alpha filter: stimulus, handshakes and the verdict.
`timescale 1ns / 1ps

module word_length_alpha_filter_tb;
    import wlaf_pkg::*;
    import wlaf_scoreboard_pkg::*;

    // Cycles to let the block finish bookkeeping for transactions that owe no
    // output (a word ending, a long emission being set up) before a register
    // write, and again before the final verdict.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 40;
    // Length of the deliberate receiver hold-off that backs up the pipeline.
    localparam int HOLD_CYCLES   = 300;
    // Non-ignored input transactions per random phase.
    localparam int PHASE_ITEMS   = 45;
    // Random phase that runs with no idling on either side.
    localparam int FREE_PHASE    = 3;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [MIN_W-1:0]   cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_has_byte;
    logic [7:0]         s_text_in;
    logic               s_line_end;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_result_kind;
    logic [7:0]         m_text_out;
    logic               m_run_last;
    logic [COUNT_W-1:0] m_words_seen;
    logic [COUNT_W-1:0] m_words_kept;
    logic               m_overlong_seen;

    // When set, neither side idles; used for one whole random phase.
    bit idle_free = 1'b0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit stall_req = 1'b0;
    int items_sent = 0;

    word_filter_scoreboard sb;

    word_length_alpha_filter dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_has_byte      (s_has_byte),
        .s_text_in       (s_text_in),
        .s_line_end      (s_line_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_text_out      (m_text_out),
        .m_run_last      (m_run_last),
        .m_words_seen    (m_words_seen),
        .m_words_kept    (m_words_kept),
        .m_overlong_seen (m_overlong_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs; a correct run finishes far sooner.
    initial begin
        #400_000;
        $display("word_length_alpha_filter: mismatch");
        $finish;
    end

    // Offer one input transaction and hold it until the block takes it.
    // Called and returns at a falling edge. Valid is only lowered when the
    // sender decides to idle, so back-to-back transactions keep it high.
    task automatic send_item(input bit has_byte, input logic [7:0] c, input bit line_end);
        while (!idle_free && $urandom_range(0, 99) < 24) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_has_byte = has_byte;
        s_text_in  = c;
        s_line_end = line_end;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_input(has_byte, c, line_end);
        // Bytes the block ignores outright do not count toward the phase size.
        if (has_byte || line_end) begin
            items_sent++;
        end
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        int idx;
        for (idx = 0; idx < s.len(); idx++) begin
            send_item(1'b1, s[idx], 1'b0);
        end
    endtask

    // Stop offering and wait until every owed output has come back, then let
    // the block settle so a register write finds it idle.
    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_min_length(input logic [MIN_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        sb.set_min_length(value);
    endtask

    function automatic logic [7:0] space_byte();
        if ($urandom_range(0, 1) == 0) begin
            return 8'h20;
        end
        return 8'h09 + 8'($urandom_range(0, 4));
    endfunction

    // A byte that belongs to a word: mostly letters of either case, otherwise
    // any byte that is not whitespace (digits, punctuation, high bytes).
    function automatic logic [7:0] word_byte(input bit alpha);
        logic [7:0] c;
        if (alpha) begin
            c = 8'h41 + 8'($urandom_range(0, 25));
            if ($urandom_range(0, 1) == 1) begin
                c = c | 8'h20;
            end
        end else begin
            do begin
                c = 8'($urandom_range(0, 255));
            end while (c inside {8'h20, [8'h09:8'h0D]});
        end
        return c;
    endfunction

    // One line of random words. Lengths cluster short, with some around the
    // buffer limit and some beyond it so overlong words show up regularly.
    task automatic send_random_line();
        int  n_words;
        int  w;
        int  idx;
        int  len;
        int  pick;
        bit  alpha;
        n_words = $urandom_range(0, 6);
        for (w = 0; w < n_words; w++) begin
            // Sprinkle noise: a random byte that may or may not be present.
            if ($urandom_range(0, 99) < 8) begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                len = $urandom_range(1, 8);
            end else if (pick < 95) begin
                len = $urandom_range(MAX_WORD - 2, MAX_WORD + 2);
            end else begin
                len = $urandom_range(MAX_WORD + 3, MAX_WORD + 8);
            end
            alpha = ($urandom_range(0, 99) < 80);
            for (idx = 0; idx < len; idx++) begin
                send_item(1'b1, word_byte(alpha), 1'b0);
            end
            send_item(1'b1, space_byte(), 1'b0);
            if ($urandom_range(0, 99) < 20) begin
                send_item(1'b1, space_byte(), 1'b0);
            end
        end
        // End the line on an empty slot, on whitespace, or on a word byte so
        // that the final word is closed by the line end itself.
        case ($urandom_range(0, 2))
            0: begin
                send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end
            1: begin
                send_item(1'b1, space_byte(), 1'b1);
            end
            default: begin
                send_item(1'b1, word_byte($urandom_range(0, 3) != 0), 1'b1);
            end
        endcase
    endtask

    // Receiver readiness: random backpressure, plus one long hold-off on request
    // so the block's internal buffering fills and it stops taking input.
    initial begin
        bit stall_done;
        stall_done = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_req && !stall_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                stall_done = 1'b1;
            end
            m_ready = idle_free || ($urandom_range(0, 99) >= 24);
        end
    end

    // Every completed output transaction is compared with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_output(m_result_kind, m_text_out, m_run_last, m_words_seen,
                            m_words_kept, m_overlong_seen);
        end
    end

    initial begin
        int phase_min[7];
        int p;
        int target;

        sb          = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_has_byte  = 1'b0;
        s_text_in   = 8'h00;
        s_line_end  = 1'b0;

        phase_min = '{0, 31, 16, 1, 17, 2, 3};
        phase_min[6] = $urandom_range(0, 31);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed line under the reset minimum length of three.
        // An absent byte is ignored even though its value is all ones.
        send_item(1'b0, 8'hFF, 1'b0);
        // Mixed case word, kept and lower-cased; becomes the longest.
        send_text("HeLlo");
        send_item(1'b1, 8'h20, 1'b0);
        // Too short to keep, but still counted as seen.
        send_text("Za");
        send_item(1'b1, 8'h0D, 1'b0);
        // Non-letters, including a high byte and zero, spoil the word.
        send_item(1'b1, "q", 1'b0);
        send_item(1'b1, 8'h80, 1'b0);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'h09, 1'b0);
        // Same length as the longest so far: kept, but does not replace it.
        send_text("WORLD");
        send_item(1'b1, 8'h0B, 1'b0);
        // One-character non-letter word closed by the line end itself.
        send_item(1'b1, 8'h40, 1'b1);
        // A line with nothing in it yields the summary alone.
        send_item(1'b0, 8'h00, 1'b1);
        drain();

        // Random phases, each under its own minimum length, extremes included.
        // The sender pauses between phases until the block has gone quiet.
        for (p = 0; p < 7; p++) begin
            write_min_length(MIN_W'(phase_min[p]));
            if (p == 0) begin
                stall_req = 1'b1;
            end
            idle_free = (p == FREE_PHASE);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                send_random_line();
            end
            drain();
            idle_free = 1'b0;
        end

        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("word_length_alpha_filter: match");
        end else begin
            $display("word_length_alpha_filter: mismatch");
        end
        $finish;
    end

endmodule
